// ===== design/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants of the tilt complementary filter
// Angle formats, the CORDIC arctangent table and a divide-by-125 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

  // CORDIC length; the arctangent table has 24 entries
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int IW           = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
  localparam int AIW          = $clog2(ATAN_ENTRIES);

  // CORDIC datapath widths: x/y hold raw*4096 plus gain, z holds Q16 degrees
  localparam int CW = 32;
  localparam int ZW = 26;
  localparam int AW = 25;  // accel angle output

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] zw_t;
  typedef logic signed [AW-1:0] acc_t;

  localparam zw_t DEG90_Q16  = 26'sd5898240;
  localparam zw_t DEG180_Q16 = 26'sd11796480;

  // gyro weight, Q16
  localparam logic [16:0] W_ONE   = 17'd65536;
  localparam logic [16:0] W_RESET = 17'd65103;

  // ceil(2^23 / 125); exact floor(n/125) for any 16-bit n
  localparam logic [16:0] RECIP125 = 17'd67109;

  localparam logic signed [31:0] ANG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ANG_MIN = 32'sh8000_0000;

  // CORDIC status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    acc_t angle;
  } cordic_res_t;

  // rounded Q16 degrees of atan(2^-i)
  function automatic zw_t atan_q16(input logic [AIW-1:0] idx);
    zw_t v;
    case (idx)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      5'd20:   v = 26'sd4;
      5'd21:   v = 26'sd2;
      5'd22:   v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // floor(n / 125) by reciprocal multiply
  function automatic logic [9:0] div125(input logic [15:0] n);
    logic [32:0] prod;
    prod = 33'(n) * 33'(RECIP125);
    return prod[32:23];
  endfunction

endpackage

`default_nettype wire

// ===== design/tcf_cordic.sv =====
// ----------------------------------------------------------------------------
// tcf_cordic: iterative vectoring CORDIC for atan2(y, z)
// One shift/add/sub step per cycle on shared x/y/z registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_cordic import tcf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] ay,
  input  wire logic signed [15:0] az,
  output cordic_res_t             res
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_ITER = 2'd1;
  localparam logic [1:0] C_FIN  = 2'd2;

  logic [1:0]    cstate;
  logic [IW-1:0] i;
  cw_t           x, y;
  zw_t           z;
  logic          zero_in;

  cw_t xs, ys, x0, y0;
  zw_t z0;
  cw_t dx, dy, x_next, y_next;
  zw_t a, z_next;

  assign xs = cw_t'(az) <<< 12;
  assign ys = cw_t'(ay) <<< 12;

  // bring the vector into the right half plane
  always_comb begin
    x0 = xs;
    y0 = ys;
    z0 = '0;
    if (xs[CW-1]) begin
      if (!ys[CW-1]) begin
        x0 = ys;
        y0 = -xs;
        z0 = DEG90_Q16;
      end else begin
        x0 = -ys;
        y0 = xs;
        z0 = -DEG90_Q16;
      end
    end
  end

  assign dx = y >>> i;
  assign dy = x >>> i;
  assign a  = atan_q16(AIW'(i));

  always_comb begin
    if (!y[CW-1]) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + a;
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate   <= C_IDLE;
      res.busy <= 1'b0;
      res.done <= 1'b0;
    end else if (start) begin
      x        <= x0;
      y        <= y0;
      z        <= z0;
      zero_in  <= (ay == 16'sd0) && (az == 16'sd0);
      i        <= '0;
      cstate   <= C_ITER;
      res.busy <= 1'b1;
      res.done <= 1'b0;
    end else begin
      case (cstate)
        C_ITER: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          i <= i + 1'b1;
          if (i == IW'(CORDIC_ITERS - 1)) begin
            cstate <= C_FIN;
          end
        end
        C_FIN: begin
          // zero input gives 0, else clamp overshoot to +-180 degrees
          if (zero_in) begin
            res.angle <= '0;
          end else if (z > DEG180_Q16) begin
            res.angle <= AW'(DEG180_Q16);
          end else if (z < -DEG180_Q16) begin
            res.angle <= AW'(-DEG180_Q16);
          end else begin
            res.angle <= AW'(z);
          end
          res.done <= 1'b1;
          res.busy <= 1'b0;
          cstate   <= C_IDLE;
        end
        default: begin
          cstate <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tilt_complementary_filter.sv =====
// ----------------------------------------------------------------------------
// tilt_complementary_filter: complementary-filter tilt estimator
// Blends an integrated gyro rate with a CORDIC accelerometer tilt, Q16 deg.
// ----------------------------------------------------------------------------
// Order: a result beat is registered after the CORDIC run that the input beat
//   starts is done, while the gyro path finishes first.
// Pacing: a new input beat is taken only after the last result is handed out,
//   so the CORDIC loop, one step a cycle, sets the pace; a stalled output holds it.
// Reset (rst, synchronous): previous angle 0, gyro_weight 65103, no beat held.
`default_nettype none

module tilt_complementary_filter import tcf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  // input beats
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // accel_y, accel_z, gyro_x, elapsed_ms
  // result beats
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,   // tilt_angle, tilt_negated, accel_angle,
                                       // gyro_rate, zero pad
  // gyro_weight register write
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [16:0]  cfg_data
);

  // sequencer codes: gyro pipeline steps, then the blend
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_G0   = 4'd1;   // rate product, ms/125
  localparam logic [3:0] S_G1   = 4'd2;   // rate, ms mod 125
  localparam logic [3:0] S_G2   = 4'd3;   // partial products
  localparam logic [3:0] S_G3   = 4'd4;   // t/125
  localparam logic [3:0] S_G4   = 4'd5;   // t mod 125
  localparam logic [3:0] S_G5   = 4'd6;   // tr*67
  localparam logic [3:0] S_G6   = 4'd7;   // (tr*67)/125
  localparam logic [3:0] S_G7   = 4'd8;   // gyro angle
  localparam logic [3:0] S_G8   = 4'd9;   // previous + gyro angle
  localparam logic [3:0] S_B1   = 4'd10;  // gyro-path product
  localparam logic [3:0] S_WAIT = 4'd11;  // wait for CORDIC, accel product
  localparam logic [3:0] S_B3   = 4'd12;  // round, saturate, hand out

  logic [3:0]  state;
  logic [16:0] gyro_weight;
  logic signed [31:0] prev_angle;

  // latched sample
  logic signed [15:0] gx;
  logic [15:0]        ms;

  // gyro path
  logic [24:0] n500;
  logic [9:0]  mq;
  logic [6:0]  mr;
  logic signed [8:0] rate;
  logic [7:0]  abs_rate;
  logic        rate_neg;
  logic [14:0] t;
  logic [17:0] hi;
  logic [7:0]  tq;
  logic [6:0]  tr;
  logic [13:0] s67;
  logic [6:0]  fq;
  logic signed [31:0] gang;
  logic signed [32:0] suma;
  logic [16:0] wc;

  // blend
  logic signed [51:0] p1;
  logic signed [41:0] p2;
  logic signed [52:0] sum;
  logic signed [36:0] q;
  logic signed [31:0] q_sat, q_neg;

  // result register
  logic signed [31:0] tilt_r, neg_r;
  acc_t               acc_r;
  logic signed [8:0]  rate_r;

  cordic_res_t cres;

  logic in_beat, out_free;
  logic [15:0] u;
  logic [16:0] rem;
  logic        rem_ge;
  logic signed [9:0] rate_w;
  logic [30:0] mag;

  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign in_beat   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign m_tdata = {6'b0, rate_r, acc_r, neg_r, tilt_r};

  tcf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (in_beat),
    .ay    (s_tdata[15:0]),
    .az    (s_tdata[31:16]),
    .res   (cres)
  );

  // gyro_x + 32768 is the raw value with its sign bit flipped
  assign u = {~gx[15], gx[14:0]};

  // n500 / 65535: estimate n>>16, one correction on the remainder
  assign rem    = 17'(n500[15:0]) + 17'(n500[24:16]);
  assign rem_ge = (rem >= 17'd65535);
  assign rate_w = $signed(10'(n500[24:16]) + 10'(rem_ge)) - 10'sd250;

  // |rate|*ms*8192/125 split as ms = 125*mq + mr, |rate|*mr = 125*tq + tr,
  // and tr*8192/125 = 65*tr + tr*67/125
  assign mag = (31'(hi) + 31'(tq)) * 31'd8192 + 31'(tr) * 31'd65 + 31'(fq);

  // blend rounding is a floor shift of sum + 1/2
  assign sum = 53'(p1) + 53'(p2) + 53'sd32768;
  assign q   = sum[52:16];

  always_comb begin
    if (q > 37'(ANG_MAX)) begin
      q_sat = ANG_MAX;
    end else if (q < 37'(ANG_MIN)) begin
      q_sat = ANG_MIN;
    end else begin
      q_sat = 32'(q);
    end
    q_neg = (q_sat == ANG_MIN) ? ANG_MAX : -q_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      prev_angle  <= '0;
      gyro_weight <= W_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gyro_weight <= cfg_data;
      end
      // in S_B3 the hand-out below owns m_tvalid
      if (m_tvalid && m_tready && (state != S_B3)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            gx    <= s_tdata[47:32];
            ms    <= s_tdata[63:48];
            state <= S_G0;
          end
        end
        S_G0: begin
          n500  <= 25'(u) * 25'd500;
          mq    <= div125(ms);
          state <= S_G1;
        end
        S_G1: begin
          rate     <= 9'(rate_w);
          rate_neg <= rate_w[9];
          abs_rate <= rate_w[9] ? 8'(-rate_w) : 8'(rate_w);
          mr       <= 7'(ms - 16'(mq) * 16'd125);
          state    <= S_G2;
        end
        S_G2: begin
          t     <= 15'(abs_rate) * 15'(mr);
          hi    <= 18'(abs_rate) * 18'(mq);
          state <= S_G3;
        end
        S_G3: begin
          tq    <= 8'(div125(16'(t)));
          state <= S_G4;
        end
        S_G4: begin
          tr    <= 7'(t - 15'(tq) * 15'd125);
          state <= S_G5;
        end
        S_G5: begin
          s67   <= 14'(tr) * 14'd67;
          state <= S_G6;
        end
        S_G6: begin
          fq    <= 7'(div125(16'(s67)));
          state <= S_G7;
        end
        S_G7: begin
          gang  <= rate_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          state <= S_G8;
        end
        S_G8: begin
          suma <= 33'(prev_angle) + 33'(gang);
          // weights above one mean a pure gyro path
          wc    <= (gyro_weight > W_ONE) ? W_ONE : gyro_weight;
          state <= S_B1;
        end
        S_B1: begin
          p1    <= 52'($signed({1'b0, wc})) * 52'(suma);
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (cres.done) begin
            p2    <= 42'($signed({1'b0, W_ONE - wc})) * 42'(cres.angle);
            state <= S_B3;
          end
        end
        S_B3: begin
          // hold here while the previous result beat is still waiting
          if (out_free) begin
            tilt_r     <= q_sat;
            neg_r      <= q_neg;
            acc_r      <= cres.angle;
            rate_r     <= rate;
            prev_angle <= q_sat;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // one item at a time: the block is busy after taking a beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready)
    else $error("input beat taken while busy");

  // the sequencer only waits on a CORDIC that is running or finished
  a_wait_cordic: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (cres.busy || cres.done))
    else $error("waiting on idle CORDIC");

  // negated angle matches the filtered angle
  a_neg_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((tilt_r == ANG_MIN) ? (neg_r == ANG_MAX) : (neg_r == -tilt_r)))
    else $error("tilt_negated mismatch");

  // accel angle inside +-180 degrees, rate inside +-250
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((acc_r <= 25'sd11796480) && (acc_r >= -25'sd11796480) &&
                  (rate_r <= 9'sd250) && (rate_r >= -9'sd250)))
    else $error("result field out of range");
`endif

endmodule

`default_nettype wire
